// ----- rtl/mchm_pkg.sv -----
// shared types and constants of the heartbeat monitor
// item and result payloads, per-channel record held in the store
// depends on nothing
package mchm_pkg;

    localparam logic [1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [1:0] OP_SCAN      = 2'd1;
    localparam logic [1:0] OP_LOAD      = 2'd2;

    localparam logic [4:0] NO_TOP = 5'd16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  channel;
        logic [31:0] current_time;
        logic        data_error;
        logic [15:0] offline_limit_in;
        logic [15:0] online_limit_in;
        logic [7:0]  priority_in;
        logic        enable_in;
        logic        check_enable_in;
    } in_item_t;

    typedef struct packed {
        logic        channel_error;
        logic [15:0] error_mask;
        logic [15:0] lost_mask;
        logic [15:0] offline_mask;
        logic        any_offline;
        logic [4:0]  top_channel;
        logic        data_error_event;
    } out_item_t;

    typedef struct packed {
        logic [31:0] newest_arrival;
        logic [31:0] previous_arrival;
        logic [31:0] settle_start;
        logic [15:0] offline_limit;
        logic [15:0] online_limit;
        logic [7:0]  rank;
        logic        monitor_on;
        logic        checker_on;
        logic        data_error_flag;
    } chan_rec_t;

    localparam chan_rec_t REC_RESET = '{
        newest_arrival:   32'd0,
        previous_arrival: 32'd0,
        settle_start:     32'd0,
        offline_limit:    16'd0,
        online_limit:     16'd0,
        rank:             8'd0,
        monitor_on:       1'b0,
        checker_on:       1'b0,
        data_error_flag:  1'b1
    };

    typedef struct packed {
        logic offline;
        logic settling;
    } judge_t;

endpackage

// ----- rtl/mchm_if.sv -----
// valid/ready channels for items and results of the heartbeat monitor
// depends on mchm_pkg
interface mchm_in_if;
    import mchm_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mchm_out_if;
    import mchm_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mchm_store.sv -----
// per-channel record store: synchronous memory with a registered read port
// valid bits make unwritten entries read as the reset record
// depends on mchm_pkg
module mchm_store #(
    parameter int CHANNELS = 16,
    parameter int IDX_W    = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  mchm_pkg::chan_rec_t wr_data,
    output mchm_pkg::chan_rec_t rd_data
);
    import mchm_pkg::*;

    chan_rec_t               mem [CHANNELS];
    chan_rec_t               rd_reg;
    logic                    rd_valid_reg;
    logic [CHANNELS-1:0]     filled_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // write-first forwarding on a same-entry collision
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_reg <= wr_data;
            end
            else
            begin
                rd_reg <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                filled_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= filled_reg[rd_addr] || (wr_en && (wr_addr == rd_addr));
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_reg : REC_RESET;

endmodule

// ----- rtl/mchm_eval.sv -----
// timeout judgement of one channel record at the current tick
// wrapping 32-bit elapsed times against the 16-bit limits
// depends on mchm_pkg
module mchm_eval (
    input  mchm_pkg::chan_rec_t rec,
    input  logic [31:0]         now,
    output mchm_pkg::judge_t    judge
);
    import mchm_pkg::*;

    logic [31:0] since_beat;
    logic [31:0] since_settle;

    assign since_beat   = now - rec.newest_arrival;
    assign since_settle = now - rec.settle_start;

    assign judge.offline  = (since_beat > {16'd0, rec.offline_limit});
    assign judge.settling = (since_settle < {16'd0, rec.online_limit});

endmodule

// ----- rtl/multi_channel_heartbeat_monitor.sv -----
// Heartbeat monitor for up to CHANNELS devices. Each item gives one result beat.
// A load or an item that changes nothing goes straight to S_DONE for its result, a heartbeat
// first through S_HB (one store read, then the write-back), and a scan through S_SCAN, which
// the single read port of the record store limits to visiting one channel a cycle.
// One item is in work at a time; the next is taken while the result waits.
// Error and lost flags live in flip-flops, the other per-channel state in the store.
// depends on mchm_pkg, mchm_if, mchm_store, mchm_eval
module multi_channel_heartbeat_monitor #(
    parameter int CHANNELS = 16
) (
    input logic        clk,
    input logic        rst_n,
    mchm_in_if.sink    items,
    mchm_out_if.source results
);
    import mchm_pkg::*;

    localparam int         IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CHANNELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HB,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg,   state_next;
    in_item_t            item_reg,    item_next;
    logic [IDX_W-1:0]    proc_reg,    proc_next;
    logic [7:0]          best_reg,    best_next;
    logic [4:0]          top_reg,     top_next;
    logic [CHANNELS-1:0] offl_reg,    offl_next;
    logic                event_reg,   event_next;
    logic [CHANNELS-1:0] err_reg,     err_next;
    logic [CHANNELS-1:0] lost_reg,    lost_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg,  out_data_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    chan_rec_t        wr_data;
    chan_rec_t        rd_data;
    judge_t           judge;

    logic             in_ok;
    logic [IDX_W-1:0] in_addr;
    logic             item_ok;
    logic [IDX_W-1:0] item_addr;

    assign in_ok     = ({1'b0, items.data.channel} < CH_LIMIT);
    assign in_addr   = items.data.channel[IDX_W-1:0];
    assign item_ok   = ({1'b0, item_reg.channel} < CH_LIMIT);
    assign item_addr = item_reg.channel[IDX_W-1:0];

    mchm_store #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    mchm_eval u_eval (
        .rec   (rd_data),
        .now   (item_reg.current_time),
        .judge (judge)
    );

    assign items.ready   = (state_reg == S_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        proc_next      = proc_reg;
        best_next      = best_reg;
        top_next       = top_reg;
        offl_next      = offl_reg;
        event_next     = event_reg;
        err_next       = err_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    item_next  = items.data;
                    event_next = 1'b0;
                    offl_next  = '0;
                    top_next   = NO_TOP;
                    best_next  = 8'd0;
                    proc_next  = '0;
                    state_next = S_DONE;
                    if ((items.data.operation == OP_LOAD) && in_ok)
                    begin
                        wr_en                    = 1'b1;
                        wr_addr                  = in_addr;
                        wr_data.newest_arrival   = items.data.current_time;
                        wr_data.previous_arrival = items.data.current_time;
                        wr_data.settle_start     = items.data.current_time;
                        wr_data.offline_limit    = items.data.offline_limit_in;
                        wr_data.online_limit     = items.data.online_limit_in;
                        wr_data.rank             = items.data.priority_in;
                        wr_data.monitor_on       = items.data.enable_in;
                        wr_data.checker_on       = items.data.check_enable_in;
                        wr_data.data_error_flag  = 1'b1;
                        err_next[in_addr]        = 1'b1;
                        lost_next[in_addr]       = 1'b1;
                    end
                    else if ((items.data.operation == OP_HEARTBEAT) && in_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = in_addr;
                        state_next = S_HB;
                    end
                    else if (items.data.operation == OP_SCAN)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_HB:
            begin
                wr_en                    = 1'b1;
                wr_addr                  = item_addr;
                wr_data.previous_arrival = rd_data.newest_arrival;
                wr_data.newest_arrival   = item_reg.current_time;
                if (lost_reg[item_addr])
                begin
                    lost_next[item_addr] = 1'b0;
                    wr_data.settle_start = item_reg.current_time;
                end
                if (rd_data.checker_on && item_reg.data_error)
                begin
                    err_next[item_addr]     = 1'b1;
                    wr_data.data_error_flag = 1'b1;
                    event_next              = 1'b1;
                end
                else
                begin
                    wr_data.data_error_flag = 1'b0;
                end
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                if (proc_reg != LAST)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = IDX_W'(proc_reg + 1'b1);
                    proc_next = IDX_W'(proc_reg + 1'b1);
                end
                else
                begin
                    state_next = S_DONE;
                end
                if (rd_data.monitor_on)
                begin
                    if (judge.offline)
                    begin
                        if (!err_reg[proc_reg])
                        begin
                            lost_next[proc_reg] = 1'b1;
                            err_next[proc_reg]  = 1'b1;
                        end
                        if (rd_data.rank > best_reg)
                        begin
                            best_next = rd_data.rank;
                            top_next  = 5'(proc_reg);
                        end
                        offl_next[proc_reg] = 1'b1;
                    end
                    else if (judge.settling)
                    begin
                        lost_next[proc_reg] = 1'b0;
                        err_next[proc_reg]  = 1'b1;
                    end
                    else
                    begin
                        lost_next[proc_reg] = 1'b0;
                        err_next[proc_reg]  = rd_data.data_error_flag;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.channel_error    = item_ok && err_reg[item_addr];
                    out_data_next.error_mask       = 16'(err_reg);
                    out_data_next.lost_mask        = 16'(lost_reg);
                    out_data_next.offline_mask     = 16'(offl_reg);
                    out_data_next.any_offline      = |offl_reg;
                    out_data_next.top_channel      = top_reg;
                    out_data_next.data_error_event = event_reg;
                    state_next                     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            proc_reg      <= '0;
            best_reg      <= 8'd0;
            top_reg       <= NO_TOP;
            offl_reg      <= '0;
            event_reg     <= 1'b0;
            err_reg       <= '1;
            lost_reg      <= '1;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            proc_reg      <= proc_next;
            best_reg      <= best_next;
            top_reg       <= top_next;
            offl_reg      <= offl_next;
            event_reg     <= event_next;
            err_reg       <= err_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_any_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.data.any_offline == (results.data.offline_mask != 16'd0)))
        else $error("any_offline disagrees with offline mask");

    a_top_is_offline: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.data.top_channel != NO_TOP))
            |-> results.data.offline_mask[results.data.top_channel[3:0]])
        else $error("top channel not in offline mask");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !wr_en)
        else $error("store written during scan");

    a_beat_clears_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HB) |=> !lost_reg[item_addr])
        else $error("heartbeat left lost flag set");
`endif

endmodule

// ----- tb/multi_channel_heartbeat_monitor_tb.sv -----
// testbench for the multi-channel heartbeat monitor: directed and random heartbeat, scan and
// load beats with a predictor of the per-channel flags, under varied idling and backpressure
// depends on mchm_pkg, mchm_if and multi_channel_heartbeat_monitor
`timescale 1ns / 1ps

module multi_channel_heartbeat_monitor_tb;
    import mchm_pkg::*;

    localparam int          CHANNELS   = 16;
    localparam logic [1:0]  OP_NONE    = 2'd3;
    localparam int          CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hold_off = 1'b0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int bad_count = 0;
    int cycle_count = 0;
    logic [31:0] tick = 32'd0;

    out_item_t status_queue[$];

    logic [31:0]         last_beat_t [CHANNELS];
    logic [31:0]         prev_beat_t [CHANNELS];
    logic [31:0]         settle_t    [CHANNELS];
    logic [15:0]         off_lim     [CHANNELS];
    logic [15:0]         on_lim      [CHANNELS];
    logic [7:0]          prio        [CHANNELS];
    logic [CHANNELS-1:0] watched;
    logic [CHANNELS-1:0] checked;
    logic [CHANNELS-1:0] err_f;
    logic [CHANNELS-1:0] lost_f;
    logic [CHANNELS-1:0] derr_f;

    mchm_in_if  items_if ();
    mchm_out_if results_if ();

    multi_channel_heartbeat_monitor #(
        .CHANNELS (CHANNELS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_channel_heartbeat_monitor test failed");
            $finish;
        end
    end

    function automatic void monitor_clear();
        for (int i = 0; i < CHANNELS; i++)
        begin
            last_beat_t[i] = '0;
            prev_beat_t[i] = '0;
            settle_t[i]    = '0;
            off_lim[i]     = '0;
            on_lim[i]      = '0;
            prio[i]        = '0;
        end
        watched = '0;
        checked = '0;
        err_f   = '1;
        lost_f  = '1;
        derr_f  = '1;
    endfunction

    function automatic out_item_t monitor_predict(in_item_t it);
        out_item_t   r;
        logic [7:0]  best;
        logic [31:0] now;
        logic [31:0] elapsed;
        logic [31:0] since_settle;
        int          c;
        r = '0;
        r.top_channel = NO_TOP;
        now = it.current_time;
        c = it.channel;
        best = 8'd0;
        case (it.operation)
            OP_LOAD:
            begin
                off_lim[c]     = it.offline_limit_in;
                on_lim[c]      = it.online_limit_in;
                prio[c]        = it.priority_in;
                watched[c]     = it.enable_in;
                checked[c]     = it.check_enable_in;
                last_beat_t[c] = now;
                prev_beat_t[c] = now;
                settle_t[c]    = now;
                err_f[c]       = 1'b1;
                lost_f[c]      = 1'b1;
                derr_f[c]      = 1'b1;
            end
            OP_HEARTBEAT:
            begin
                prev_beat_t[c] = last_beat_t[c];
                last_beat_t[c] = now;
                if (lost_f[c])
                begin
                    lost_f[c]   = 1'b0;
                    settle_t[c] = now;
                end
                if (checked[c] && it.data_error)
                begin
                    err_f[c]  = 1'b1;
                    derr_f[c] = 1'b1;
                    r.data_error_event = 1'b1;
                end
                else
                begin
                    derr_f[c] = 1'b0;
                end
            end
            OP_SCAN:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (watched[i])
                    begin
                        elapsed      = now - last_beat_t[i];
                        since_settle = now - settle_t[i];
                        if (elapsed > {16'd0, off_lim[i]})
                        begin
                            if (!err_f[i])
                            begin
                                lost_f[i] = 1'b1;
                                err_f[i]  = 1'b1;
                            end
                            if (prio[i] > best)
                            begin
                                best = prio[i];
                                r.top_channel = 5'(i);
                            end
                            r.offline_mask[i] = 1'b1;
                            r.any_offline = 1'b1;
                        end
                        else if (since_settle < {16'd0, on_lim[i]})
                        begin
                            lost_f[i] = 1'b0;
                            err_f[i]  = 1'b1;
                        end
                        else
                        begin
                            lost_f[i] = 1'b0;
                            err_f[i]  = derr_f[i];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.channel_error = err_f[c];
        r.error_mask    = err_f;
        r.lost_mask     = lost_f;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, got_v);
        end
    endfunction

    function automatic void check_status(out_item_t got);
        out_item_t exp_r;
        if (status_queue.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("unexpected result beat %h", got);
            return;
        end
        exp_r = status_queue.pop_front();
        check_field("channel_error", 32'(exp_r.channel_error), 32'(got.channel_error));
        check_field("error_mask", 32'(exp_r.error_mask), 32'(got.error_mask));
        check_field("lost_mask", 32'(exp_r.lost_mask), 32'(got.lost_mask));
        check_field("offline_mask", 32'(exp_r.offline_mask), 32'(got.offline_mask));
        check_field("any_offline", 32'(exp_r.any_offline), 32'(got.any_offline));
        check_field("top_channel", 32'(exp_r.top_channel), 32'(got.top_channel));
        check_field("data_error_event", 32'(exp_r.data_error_event),
                    32'(got.data_error_event));
    endfunction

    // result side: check on handshake, then choose ready for the next edge
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_if.valid && results_if.ready)
                check_status(results_if.data);
            results_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_beat(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.data  <= it;
        do
            @(posedge clk);
        while (!items_if.ready);
        status_queue.push_back(monitor_predict(it));
    endtask

    function automatic in_item_t noise_item();
        in_item_t it;
        it.operation        = 2'($urandom_range(3));
        it.channel          = 4'($urandom_range(15));
        it.current_time     = $urandom;
        it.data_error       = 1'($urandom_range(1));
        it.offline_limit_in = 16'($urandom);
        it.online_limit_in  = 16'($urandom);
        it.priority_in      = 8'($urandom);
        it.enable_in        = 1'($urandom_range(1));
        it.check_enable_in  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        it = noise_item();
        pick = $urandom_range(99);
        tick = tick + 32'($urandom_range(4));
        if (pick < 12)
            it.operation = OP_LOAD;
        else if (pick < 55)
            it.operation = OP_HEARTBEAT;
        else if (pick < 96)
            it.operation = OP_SCAN;
        else
            it.operation = OP_NONE;
        if ($urandom_range(99) >= 3)
            it.current_time = tick;
        it.data_error = ($urandom_range(99) < 25);
        if ($urandom_range(99) < 80)
        begin
            it.offline_limit_in = 16'($urandom_range(120));
            it.online_limit_in  = 16'($urandom_range(60));
        end
        if ($urandom_range(99) < 50)
            it.priority_in = 8'($urandom_range(3) * 64);
        it.enable_in = ($urandom_range(99) < 85);
        return it;
    endfunction

    task automatic send_load(input logic [3:0] ch, input logic [31:0] t,
                             input logic [15:0] off, input logic [15:0] on,
                             input logic [7:0] pri, input logic en, input logic chk);
        in_item_t it;
        it = noise_item();
        it.operation        = OP_LOAD;
        it.channel          = ch;
        it.current_time     = t;
        it.offline_limit_in = off;
        it.online_limit_in  = on;
        it.priority_in      = pri;
        it.enable_in        = en;
        it.check_enable_in  = chk;
        send_beat(it);
    endtask

    task automatic send_heartbeat(input logic [3:0] ch, input logic [31:0] t, input logic derr);
        in_item_t it;
        it = noise_item();
        it.operation    = OP_HEARTBEAT;
        it.channel      = ch;
        it.current_time = t;
        it.data_error   = derr;
        send_beat(it);
    endtask

    task automatic send_plain(input logic [1:0] op, input logic [3:0] ch, input logic [31:0] t);
        in_item_t it;
        it = noise_item();
        it.operation    = op;
        it.channel      = ch;
        it.current_time = t;
        send_beat(it);
    endtask

    task automatic test_directed();
        logic [31:0] t0;
        t0 = 32'hFFFF_FFF0;
        send_idle_pct = 0;
        stall_pct = 0;
        send_plain(OP_NONE, 4'd5, 32'd0);
        send_plain(OP_SCAN, 4'd0, 32'd0);
        send_load(4'd0, t0, 16'd10, 16'd5, 8'd0, 1'b1, 1'b1);
        send_load(4'd15, t0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
        send_load(4'd3, t0, 16'd0, 16'd0, 8'd7, 1'b1, 1'b1);
        send_load(4'd4, t0, 16'd0, 16'd0, 8'd7, 1'b1, 1'b0);
        send_load(4'd7, t0, 16'd0, 16'd0, 8'd200, 1'b0, 1'b0);
        send_plain(OP_SCAN, 4'd9, t0);
        send_heartbeat(4'd3, t0 + 32'd2, 1'b1);
        send_heartbeat(4'd4, t0 + 32'd2, 1'b1);
        send_heartbeat(4'd0, t0 + 32'd3, 1'b0);
        send_plain(OP_SCAN, 4'd3, t0 + 32'd3);
        send_plain(OP_SCAN, 4'd0, t0 + 32'd20);
        send_heartbeat(4'd0, t0 + 32'd21, 1'b1);
        send_plain(OP_SCAN, 4'd0, t0 + 32'd30);
        send_heartbeat(4'd0, t0 + 32'd31, 1'b0);
        send_plain(OP_SCAN, 4'd0, t0 + 32'd40);
        send_plain(OP_SCAN, 4'd0, t0 + 32'd52);
        send_plain(OP_NONE, 4'd0, t0 + 32'd53);
        send_load(4'd15, t0 + 32'd60, 16'hFFFF, 16'd0, 8'hFF, 1'b0, 1'b1);
        send_heartbeat(4'd7, t0 + 32'd61, 1'b1);
        send_plain(OP_SCAN, 4'd15, 32'h7FFF_FFFF);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_in, input logic [31:0] start_tick);
        send_idle_pct = idle_pct;
        stall_pct = stall_in;
        tick = start_tick;
        repeat (count)
            send_beat(random_item());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (40)
            send_beat(random_item());
    endtask

    initial
    begin
        items_if.valid = 1'b0;
        items_if.data  = '0;
        monitor_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(430, 0, 0, $urandom);
        test_random_traffic(430, 68, 0, 32'hFFFF_F000);
        test_random_traffic(430, 0, 68, $urandom);
        test_random_traffic(430, 20, 20, $urandom);
        test_backpressure();
        items_if.valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (bad_count == 0)
            $display("multi_channel_heartbeat_monitor test passed");
        else
            $display("multi_channel_heartbeat_monitor test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mchm_pkg.sv
rtl/mchm_if.sv
rtl/mchm_store.sv
rtl/mchm_eval.sv
rtl/multi_channel_heartbeat_monitor.sv
tb/multi_channel_heartbeat_monitor_tb.sv
